// File: rtl/mcpt_pkg.sv
package mcpt_pkg;

  // Table geometry
  localparam int NUM_SLOTS   = 16;
  localparam int MAX_RESULTS = 16;
  localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // Field widths
  localparam int KIND_W    = 2;
  localparam int ID_W      = 16;
  localparam int PERIOD_W  = 31;
  localparam int ELAPSED_W = 16;
  localparam int RES_W     = 3;

  // Request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_SET  = 2'd0,
    KIND_KILL = 2'd1,
    KIND_TICK = 2'd2
  } kind_t;

  // Result codes
  typedef enum logic [RES_W-1:0] {
    EV_EXPIRED  = 3'd0,
    EV_UPDATED  = 3'd1,
    EV_ADDED    = 3'd2,
    EV_FULL     = 3'd3,
    EV_KILLED   = 3'd4,
    EV_NOTFOUND = 3'd5
  } event_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;
    logic commit_set;
    logic report_kill;
    logic report_tick;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic              scan_done;
    logic [KIND_W-1:0] kind;
  } sts_t;

endpackage

// File: rtl/mcpt_ctrl.sv
module mcpt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output mcpt_pkg::cmd_t   cmd,
  input  mcpt_pkg::sts_t   sts
);

  mcpt_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mcpt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mcpt_pkg::ST_IDLE: begin
        if (start) state_nxt = mcpt_pkg::ST_SCAN;
      end
      mcpt_pkg::ST_SCAN: begin
        if (sts.scan_done) state_nxt = mcpt_pkg::ST_FINISH;
      end
      mcpt_pkg::ST_FINISH: begin
        state_nxt = mcpt_pkg::ST_IDLE;
      end
      default: state_nxt = mcpt_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd  = '0;
    busy = (state_r != mcpt_pkg::ST_IDLE);
    unique case (state_r)
      mcpt_pkg::ST_IDLE: begin
        cmd.load = start;
      end
      mcpt_pkg::ST_SCAN: begin
      end
      mcpt_pkg::ST_FINISH: begin
        // pick the closing action by request kind; unused kind does nothing
        unique case (sts.kind)
          mcpt_pkg::KIND_SET:  cmd.commit_set  = 1'b1;
          mcpt_pkg::KIND_KILL: cmd.report_kill = 1'b1;
          mcpt_pkg::KIND_TICK: cmd.report_tick = 1'b1;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/mcpt_datapath.sv
module mcpt_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mcpt_pkg::cmd_t                 cmd,
  output mcpt_pkg::sts_t                 sts,
  input  logic [mcpt_pkg::KIND_W-1:0]    in_kind,
  input  logic [mcpt_pkg::ID_W-1:0]      in_timer_id,
  input  logic [mcpt_pkg::PERIOD_W-1:0]  in_period_ms,
  input  logic [mcpt_pkg::ELAPSED_W-1:0] in_elapsed_ms,
  output logic                           out_valid,
  output logic [mcpt_pkg::RES_W-1:0]     out_event_res,
  output logic [mcpt_pkg::ID_W-1:0]      out_event_id,
  output logic                           out_last
);

  localparam logic [mcpt_pkg::SLOT_W-1:0] LAST_IDX =
    mcpt_pkg::SLOT_W'(mcpt_pkg::NUM_SLOTS - 1);

  // Latched request
  logic [mcpt_pkg::KIND_W-1:0]    kind_r;
  logic [mcpt_pkg::ID_W-1:0]      id_r;
  logic [mcpt_pkg::PERIOD_W-1:0]  period_r;
  logic [mcpt_pkg::ELAPSED_W-1:0] elapsed_r;

  // Slot memories, registered read
  logic [mcpt_pkg::ID_W-1:0]     id_mem  [mcpt_pkg::NUM_SLOTS];
  logic [mcpt_pkg::PERIOD_W-1:0] per_mem [mcpt_pkg::NUM_SLOTS];
  logic [mcpt_pkg::PERIOD_W-1:0] rem_mem [mcpt_pkg::NUM_SLOTS];
  logic [mcpt_pkg::ID_W-1:0]     id_q_r;
  logic [mcpt_pkg::PERIOD_W-1:0] per_q_r;
  logic [mcpt_pkg::PERIOD_W-1:0] rem_q_r;

  // Write ports
  logic                          id_we, per_we, rem_we;
  logic [mcpt_pkg::SLOT_W-1:0]   id_wa, per_wa, rem_wa;
  logic [mcpt_pkg::ID_W-1:0]     id_wd;
  logic [mcpt_pkg::PERIOD_W-1:0] per_wd, rem_wd;

  // Valid marks
  logic [mcpt_pkg::NUM_SLOTS-1:0] slot_valid_r, slot_valid_nxt;

  // Scan pipeline: read issue, then compare stage
  logic                        rd_go_r, rd_go_nxt;
  logic [mcpt_pkg::SLOT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic                        s1_vld_r, s1_vld_nxt;
  logic [mcpt_pkg::SLOT_W-1:0] s1_idx_r;

  // Scan results
  logic                        hit_r, hit_nxt;
  logic [mcpt_pkg::SLOT_W-1:0] hit_idx_r, hit_idx_nxt;
  logic                        free_r, free_nxt;
  logic [mcpt_pkg::SLOT_W-1:0] free_idx_r, free_idx_nxt;
  logic                        kill_any_r, kill_any_nxt;
  logic                        pend_r, pend_nxt;
  logic [mcpt_pkg::ID_W-1:0]   pend_id_r, pend_id_nxt;
  logic [mcpt_pkg::CNT_W-1:0]  exp_cnt_r, exp_cnt_nxt;

  // Result register
  logic                         out_valid_r, out_valid_nxt;
  logic [mcpt_pkg::RES_W-1:0]   out_res_r, out_res_nxt;
  logic [mcpt_pkg::ID_W-1:0]    out_id_r, out_id_nxt;
  logic                         out_last_r, out_last_nxt;

  logic cur_valid, id_eq, expire;

  assign cur_valid = slot_valid_r[s1_idx_r];
  assign id_eq     = (id_q_r == id_r);
  assign expire    = (rem_q_r <= mcpt_pkg::PERIOD_W'(elapsed_r));

  assign sts.scan_done = s1_vld_r && (s1_idx_r == LAST_IDX);
  assign sts.kind      = kind_r;

  assign out_valid     = out_valid_r;
  assign out_event_res = out_res_r;
  assign out_event_id  = out_id_r;
  assign out_last      = out_last_r;

  // Scan and update logic
  always_comb begin
    rd_go_nxt      = rd_go_r;
    rd_idx_nxt     = rd_idx_r;
    s1_vld_nxt     = rd_go_r && !cmd.load;
    slot_valid_nxt = slot_valid_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    kill_any_nxt   = kill_any_r;
    pend_nxt       = pend_r;
    pend_id_nxt    = pend_id_r;
    exp_cnt_nxt    = exp_cnt_r;
    out_valid_nxt  = 1'b0;
    out_res_nxt    = out_res_r;
    out_id_nxt     = out_id_r;
    out_last_nxt   = out_last_r;
    id_we  = 1'b0;
    per_we = 1'b0;
    rem_we = 1'b0;
    id_wa  = s1_idx_r;
    per_wa = s1_idx_r;
    rem_wa = s1_idx_r;
    id_wd  = id_r;
    per_wd = period_r;
    rem_wd = period_r;

    // read address sequencing
    if (cmd.load) begin
      rd_go_nxt    = 1'b1;
      rd_idx_nxt   = '0;
      hit_nxt      = 1'b0;
      free_nxt     = 1'b0;
      kill_any_nxt = 1'b0;
      pend_nxt     = 1'b0;
      exp_cnt_nxt  = '0;
    end else if (rd_go_r) begin
      rd_idx_nxt = rd_idx_r + mcpt_pkg::SLOT_W'(1);
      if (rd_idx_r == LAST_IDX) rd_go_nxt = 1'b0;
    end

    // per-slot work on the slot just read
    if (s1_vld_r) begin
      case (kind_r)
        mcpt_pkg::KIND_SET: begin
          if (cur_valid) begin
            if (!hit_r && id_eq) begin
              hit_nxt     = 1'b1;
              hit_idx_nxt = s1_idx_r;
            end
          end else if (!free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = s1_idx_r;
          end
        end
        mcpt_pkg::KIND_KILL: begin
          if (cur_valid && id_eq) begin
            slot_valid_nxt[s1_idx_r] = 1'b0;
            kill_any_nxt             = 1'b1;
          end
        end
        mcpt_pkg::KIND_TICK: begin
          if (cur_valid) begin
            rem_we = 1'b1;
            if (expire) begin
              rem_wd = per_q_r;
              // hold the newest expiry back so the final one can carry last
              if (exp_cnt_r < mcpt_pkg::CNT_W'(mcpt_pkg::MAX_RESULTS)) begin
                if (pend_r) begin
                  out_valid_nxt = 1'b1;
                  out_res_nxt   = mcpt_pkg::EV_EXPIRED;
                  out_id_nxt    = pend_id_r;
                  out_last_nxt  = 1'b0;
                end
                pend_nxt    = 1'b1;
                pend_id_nxt = id_q_r;
                exp_cnt_nxt = exp_cnt_r + mcpt_pkg::CNT_W'(1);
              end
            end else begin
              rem_wd = rem_q_r - mcpt_pkg::PERIOD_W'(elapsed_r);
            end
          end
        end
        default: ;
      endcase
    end

    // closing actions
    if (cmd.commit_set) begin
      out_valid_nxt = 1'b1;
      out_id_nxt    = id_r;
      out_last_nxt  = 1'b1;
      if (hit_r) begin
        per_we      = 1'b1;
        per_wa      = hit_idx_r;
        rem_we      = 1'b1;
        rem_wa      = hit_idx_r;
        rem_wd      = period_r;
        out_res_nxt = mcpt_pkg::EV_UPDATED;
      end else if (free_r) begin
        slot_valid_nxt[free_idx_r] = 1'b1;
        id_we       = 1'b1;
        id_wa       = free_idx_r;
        per_we      = 1'b1;
        per_wa      = free_idx_r;
        rem_we      = 1'b1;
        rem_wa      = free_idx_r;
        rem_wd      = period_r;
        out_res_nxt = mcpt_pkg::EV_ADDED;
      end else begin
        out_res_nxt = mcpt_pkg::EV_FULL;
      end
    end
    if (cmd.report_kill) begin
      out_valid_nxt = 1'b1;
      out_id_nxt    = id_r;
      out_last_nxt  = 1'b1;
      out_res_nxt   = kill_any_r ? mcpt_pkg::EV_KILLED : mcpt_pkg::EV_NOTFOUND;
    end
    if (cmd.report_tick && pend_r) begin
      out_valid_nxt = 1'b1;
      out_id_nxt    = pend_id_r;
      out_last_nxt  = 1'b1;
      out_res_nxt   = mcpt_pkg::EV_EXPIRED;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_go_r      <= 1'b0;
      s1_vld_r     <= 1'b0;
      slot_valid_r <= '0;
      hit_r        <= 1'b0;
      free_r       <= 1'b0;
      kill_any_r   <= 1'b0;
      pend_r       <= 1'b0;
      exp_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      rd_go_r      <= rd_go_nxt;
      s1_vld_r     <= s1_vld_nxt;
      slot_valid_r <= slot_valid_nxt;
      hit_r        <= hit_nxt;
      free_r       <= free_nxt;
      kill_any_r   <= kill_any_nxt;
      pend_r       <= pend_nxt;
      exp_cnt_r    <= exp_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r    <= in_kind;
      id_r      <= in_timer_id;
      period_r  <= in_period_ms;
      elapsed_r <= in_elapsed_ms;
    end
    rd_idx_r   <= rd_idx_nxt;
    s1_idx_r   <= rd_idx_r;
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
    pend_id_r  <= pend_id_nxt;
    out_res_r  <= out_res_nxt;
    out_id_r   <= out_id_nxt;
    out_last_r <= out_last_nxt;
  end

  // Slot memories
  always_ff @(posedge clk) begin
    if (id_we) id_mem[id_wa] <= id_wd;
    id_q_r <= id_mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (per_we) per_mem[per_wa] <= per_wd;
    per_q_r <= per_mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (rem_we) rem_mem[rem_wa] <= rem_wd;
    rem_q_r <= rem_mem[rd_idx_r];
  end

endmodule

// File: rtl/multi_channel_periodic_timer_top.sv
// Periodic timer table with NUM_SLOTS slots. A request is taken when start is
// high and busy is low; each request walks every slot once through the
// slot memories (one read per cycle plus one compare stage), and busy stays
// high through the scan and its closing step, so no new request is taken
// before the previous one is through. Set and kill requests give one result;
// a tick gives one expiry result per expiring slot, in slot order, or none;
// the unused kind gives none. Results appear on out_* for exactly one cycle,
// marked by out_valid, with out_last on the final one of a request. The
// receiver cannot stall: it must take every result in the cycle it is shown.
// Expiries stream out during the scan, and the last result of a request may
// appear in the cycle after busy falls.
module multi_channel_periodic_timer_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [mcpt_pkg::KIND_W-1:0]    in_kind,
  input  logic [mcpt_pkg::ID_W-1:0]      in_timer_id,
  input  logic [mcpt_pkg::PERIOD_W-1:0]  in_period_ms,
  input  logic [mcpt_pkg::ELAPSED_W-1:0] in_elapsed_ms,
  output logic                           out_valid,
  output logic [mcpt_pkg::RES_W-1:0]     out_event_res,
  output logic [mcpt_pkg::ID_W-1:0]      out_event_id,
  output logic                           out_last
);

  mcpt_pkg::cmd_t cmd;
  mcpt_pkg::sts_t sts;

  mcpt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  mcpt_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_kind       (in_kind),
    .in_timer_id   (in_timer_id),
    .in_period_ms  (in_period_ms),
    .in_elapsed_ms (in_elapsed_ms),
    .out_valid     (out_valid),
    .out_event_res (out_event_res),
    .out_event_id  (out_event_id),
    .out_last      (out_last)
  );

endmodule

// File: rtl/mcpt_checker.sv
module mcpt_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_valid,
  input logic [mcpt_pkg::RES_W-1:0] out_event_res,
  input logic                       out_last
);

  // an accepted request makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request accepted but busy not raised");

  // a result shown while idle must close its request
  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !busy |-> out_last)
    else $error("non-final result after request completed");

  // only expiries come in runs; anything else is the sole result
  a_run_expired: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_event_res == mcpt_pkg::EV_EXPIRED)
    else $error("non-final result that is not an expiry");

  // result code stays in the defined range
  a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_event_res == mcpt_pkg::EV_EXPIRED ||
                   out_event_res == mcpt_pkg::EV_UPDATED ||
                   out_event_res == mcpt_pkg::EV_ADDED ||
                   out_event_res == mcpt_pkg::EV_FULL ||
                   out_event_res == mcpt_pkg::EV_KILLED ||
                   out_event_res == mcpt_pkg::EV_NOTFOUND))
    else $error("undefined result code");

  // no result in the first cycle of a new request
  a_start_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> !out_valid)
    else $error("result shown as a request begins");

endmodule

bind multi_channel_periodic_timer_top mcpt_checker u_mcpt_checker (.*);

// File: test/multi_channel_periodic_timer_top_test.sv
`timescale 1ns / 100ps

module multi_channel_periodic_timer_top_test;
  import mcpt_pkg::*;

  // Unused request kind, must be ignored by the block
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 100;
  localparam int CALM_TAIL    = 30;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int ID_POOL      = 24;

  typedef struct {
    logic [KIND_W-1:0]    kind;
    logic [ID_W-1:0]      timer_id;
    logic [PERIOD_W-1:0]  period;
    logic [ELAPSED_W-1:0] elapsed;
    bit                   drain;
  } request_t;

  typedef struct {
    event_t          res;
    logic [ID_W-1:0] id;
    logic            last;
  } timer_event_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [KIND_W-1:0]    in_kind = '0;
  logic [ID_W-1:0]      in_timer_id = '0;
  logic [PERIOD_W-1:0]  in_period_ms = '0;
  logic [ELAPSED_W-1:0] in_elapsed_ms = '0;
  logic                 out_valid;
  logic [RES_W-1:0]     out_event_res;
  logic [ID_W-1:0]      out_event_id;
  logic                 out_last;

  // Requests waiting to be sent, and results still owed by the block
  request_t     request_q[$];
  timer_event_t event_q[$];

  // Shadow copy of the timer table
  logic                tbl_valid [NUM_SLOTS];
  logic [ID_W-1:0]     tbl_id    [NUM_SLOTS];
  logic [PERIOD_W-1:0] tbl_period[NUM_SLOTS];
  logic [PERIOD_W-1:0] tbl_left  [NUM_SLOTS];

  logic [ID_W-1:0] id_pool[ID_POOL];
  int gap_left = 0;
  int cycle_cnt = 0;
  int fail_cnt = 0;
  int accepted_cnt = 0;
  int seen_res[8];

  always #2 clk = ~clk;

  multi_channel_periodic_timer_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_kind      (in_kind),
    .in_timer_id  (in_timer_id),
    .in_period_ms (in_period_ms),
    .in_elapsed_ms(in_elapsed_ms),
    .out_valid    (out_valid),
    .out_event_res(out_event_res),
    .out_event_id (out_event_id),
    .out_last     (out_last)
  );

  task automatic add_request(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                             input logic [PERIOD_W-1:0] period,
                             input logic [ELAPSED_W-1:0] elapsed, input bit drain);
    request_t r;
    r.kind     = kind;
    r.timer_id = id;
    r.period   = period;
    r.elapsed  = elapsed;
    r.drain    = drain;
    request_q.push_back(r);
  endtask

  // Apply one request to the shadow table and queue the results it owes
  task automatic table_apply(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                             input logic [PERIOD_W-1:0] period,
                             input logic [ELAPSED_W-1:0] elapsed);
    int hit;
    int free_slot;
    int fired;
    bit any;
    event_t res;
    hit = -1;
    free_slot = -1;
    fired = 0;
    any = 1'b0;
    case (kind)
      KIND_SET: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (tbl_valid[i]) begin
            if (hit < 0 && tbl_id[i] == id) hit = i;
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        if (hit >= 0) begin
          tbl_period[hit] = period;
          tbl_left[hit]   = period;
          res = EV_UPDATED;
        end else if (free_slot >= 0) begin
          tbl_valid[free_slot]  = 1'b1;
          tbl_id[free_slot]     = id;
          tbl_period[free_slot] = period;
          tbl_left[free_slot]   = period;
          res = EV_ADDED;
        end else begin
          res = EV_FULL;
        end
        event_q.push_back('{res, id, 1'b1});
      end
      KIND_KILL: begin
        // kill frees every slot carrying the id
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (tbl_valid[i] && tbl_id[i] == id) begin
            tbl_valid[i] = 1'b0;
            any = 1'b1;
          end
        end
        event_q.push_back('{any ? EV_KILLED : EV_NOTFOUND, id, 1'b1});
      end
      KIND_TICK: begin
        // expired slots reload to full period, no overshoot carried
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (tbl_valid[i]) begin
            if (tbl_left[i] <= PERIOD_W'(elapsed)) begin
              tbl_left[i] = tbl_period[i];
              if (fired < MAX_RESULTS) begin
                event_q.push_back('{EV_EXPIRED, tbl_id[i], 1'b0});
                fired++;
              end
            end else begin
              tbl_left[i] = tbl_left[i] - PERIOD_W'(elapsed);
            end
          end
        end
        if (fired > 0) event_q[event_q.size() - 1].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  // Driver: present the head request, with random idle bursts and drain pauses
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left--;
    end else if (request_q.size() == 0 || (request_q[0].drain && event_q.size() != 0)) begin
      start <= 1'b0;
    end else if (request_q.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      gap_left = $urandom_range(0, 3);
    end else begin
      start         <= 1'b1;
      in_kind       <= request_q[0].kind;
      in_timer_id   <= request_q[0].timer_id;
      in_period_ms  <= request_q[0].period;
      in_elapsed_ms <= request_q[0].elapsed;
    end
  end

  // Monitor: check results against the oldest owed one, then predict new requests
  always @(posedge clk) begin
    timer_event_t want;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_cnt, event_q.size());
      $display("TEST FAILED");
      $finish;
    end else if (rst_n) begin
      if (out_valid) begin
        if (event_q.size() == 0) begin
          $error("result with none owed: event_res %0d event_id %h last %b",
                 out_event_res, out_event_id, out_last);
          fail_cnt++;
        end else begin
          want = event_q.pop_front();
          if (out_event_res !== want.res) begin
            $error("event_res: expected %0d, got %0d", want.res, out_event_res);
            fail_cnt++;
          end
          if (out_event_id !== want.id) begin
            $error("event_id: expected %h, got %h", want.id, out_event_id);
            fail_cnt++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_last);
            fail_cnt++;
          end
          seen_res[want.res]++;
        end
      end
      if (start && !busy) begin
        table_apply(in_kind, in_timer_id, in_period_ms, in_elapsed_ms);
        void'(request_q.pop_front());
        accepted_cnt++;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int counted;
    int pick;
    logic [ID_W-1:0] id;
    logic [PERIOD_W-1:0] period;
    logic [ELAPSED_W-1:0] elapsed;

    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
    foreach (seen_res[i]) seen_res[i] = 0;
    foreach (id_pool[i]) id_pool[i] = ID_W'($urandom());
    id_pool[0] = '0;
    id_pool[1] = '1;

    // Directed: empty table, zero period, extremes, spare kind, full table
    add_request(KIND_TICK, 16'h0000, '0, 16'h0000, 1'b0);
    add_request(KIND_KILL, 16'hFFFF, '0, 16'h0000, 1'b0);
    add_request(KIND_SET, 16'h0000, '0, 16'h0000, 1'b0);
    add_request(KIND_TICK, 16'h0000, '0, 16'h0000, 1'b0);
    add_request(KIND_SET, 16'hFFFF, 31'h7FFF_FFFF, 16'h0000, 1'b0);
    add_request(KIND_TICK, 16'h0000, '0, 16'hFFFF, 1'b0);
    add_request(KIND_SET, 16'h0000, 31'd3, 16'h0000, 1'b0);
    add_request(KIND_SPARE, 16'hFFFF, 31'h7FFF_FFFF, 16'hFFFF, 1'b0);
    add_request(KIND_KILL, 16'h0000, '0, 16'h0000, 1'b0);
    for (int k = 0; k < NUM_SLOTS - 1; k++)
      add_request(KIND_SET, 16'h0100 + ID_W'(k), PERIOD_W'($urandom_range(0, 40000)),
                  16'h0000, 1'b0);
    add_request(KIND_SET, 16'h0200, 31'd10, 16'h0000, 1'b0);
    add_request(KIND_TICK, 16'h0000, '0, 16'hFFFF, 1'b1);

    // Random: ids from a small pool so sets reload and kills hit
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      id = ($urandom_range(0, 9) == 0) ? ID_W'($urandom())
                                       : id_pool[$urandom_range(0, ID_POOL - 1)];
      case ($urandom_range(0, 9))
        0:       period = '0;
        1, 2:    period = PERIOD_W'($urandom());
        default: period = PERIOD_W'($urandom_range(0, 3000));
      endcase
      case ($urandom_range(0, 6))
        0:       elapsed = '0;
        1:       elapsed = ELAPSED_W'($urandom());
        default: elapsed = ELAPSED_W'($urandom_range(0, 1500));
      endcase
      if (pick < 40) begin
        add_request(KIND_SET, id, period, ELAPSED_W'($urandom()), counted % 40 == 39);
        counted++;
      end else if (pick < 60) begin
        add_request(KIND_KILL, id, PERIOD_W'($urandom()), ELAPSED_W'($urandom()),
                    counted % 40 == 39);
        counted++;
      end else if (pick < 95) begin
        add_request(KIND_TICK, ID_W'($urandom()), PERIOD_W'($urandom()), elapsed,
                    counted % 40 == 39);
        counted++;
      end else begin
        add_request(KIND_SPARE, id, period, elapsed, 1'b0);
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (request_q.size() != 0 || event_q.size() != 0) @(posedge clk);
    repeat (NUM_SLOTS + 8) @(posedge clk);

    $display("run took %0d requests: %0d added, %0d reloaded, %0d refused on a full table",
             accepted_cnt, seen_res[EV_ADDED], seen_res[EV_UPDATED], seen_res[EV_FULL]);
    $display("  %0d kills, %0d kills of absent ids, %0d expiries, %0d mismatches",
             seen_res[EV_KILLED], seen_res[EV_NOTFOUND], seen_res[EV_EXPIRED], fail_cnt);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
